@@ rtl/palette_color_shade_generator_defines.svh @@
// Assertion macros shared by the palette color shade generator modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef PALETTE_COLOR_SHADE_GENERATOR_DEFINES_SVH
`define PALETTE_COLOR_SHADE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pcsg_pkg.sv @@
// Package for the palette color shade generator: types, constants and the
// constant-divisor helper functions. No dependencies.
package pcsg_pkg;

  localparam int NUM_STAGES = 8;
  localparam int PADDR_W = 4;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  typedef enum logic [1:0] {
    REG_TINT       = 2'd0,
    REG_BRIGHTNESS = 2'd1,
    REG_CONTRAST   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] tint_rgb;
    logic [15:0] brightness;
    logic [15:0] contrast;
  } cfg_t;

  localparam logic [23:0] TINT_RESET = 24'hFFFFFF;
  localparam logic [15:0] BRIGHTNESS_RESET = 16'd255;
  localparam logic [15:0] CONTRAST_RESET = 16'd255;

  localparam logic [8:0] CONTRAST_BIAS = 9'd127;
  localparam logic [5:0] MAX_LEVEL = 6'd32;
  localparam logic [5:0] NEUTRAL_LO = 6'd15;
  localparam logic [5:0] NEUTRAL_HI = 6'd16;
  // Past 256 * 15 the shade step always saturates (or gives 0 at level 0).
  localparam logic [11:0] SHADE_SAT = 12'd3840;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Floor division by 255 using the reciprocal 0x01010101 / 2^32 and one
  // correction step.
  function automatic logic [25:0] div255(input logic [33:0] p);
    logic [59:0] acc;
    logic [27:0] q;
    logic [33:0] r;
    acc = {26'b0, p} + {18'b0, p, 8'b0} + {10'b0, p, 16'b0} + {2'b0, p, 24'b0};
    q = acc[59:32];
    r = p - ({6'b0, q} << 8) + {6'b0, q};
    if (r >= 34'd255) begin
      q = q + 28'd1;
    end
    return q[25:0];
  endfunction

  // Floor division by 15 for values below 3840.
  function automatic logic [7:0] div15(input logic [11:0] p);
    logic [27:0] acc;
    logic [11:0] q;
    logic [11:0] r;
    acc = {16'b0, p} + {12'b0, p, 4'b0} + {8'b0, p, 8'b0} + {4'b0, p, 12'b0};
    q = acc[27:16];
    r = p - (q << 4) + q;
    if (r >= 12'd15) begin
      q = q + 12'd1;
    end
    return q[7:0];
  endfunction

  // Shade gain in fifteenths for a shade level.
  function automatic logic [5:0] shade_factor(input logic [5:0] level);
    logic [5:0] lv;
    logic [6:0] dbl;
    logic [5:0] f;
    lv = (level > MAX_LEVEL) ? MAX_LEVEL : level;
    dbl = {lv, 1'b0} - {1'b0, NEUTRAL_LO};
    if (lv < NEUTRAL_LO) begin
      f = lv;
    end else if (lv <= NEUTRAL_HI) begin
      f = NEUTRAL_LO;
    end else begin
      f = dbl[5:0];
    end
    return f;
  endfunction

endpackage

@@ rtl/pcsg_cfg.sv @@
// Configuration register file with an APB-style port.
// Depends on pcsg_pkg for the register indexes, reset values and cfg_t.
module pcsg_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcsg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output pcsg_pkg::cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tint_rgb <= pcsg_pkg::TINT_RESET;
      cfg.brightness <= pcsg_pkg::BRIGHTNESS_RESET;
      cfg.contrast <= pcsg_pkg::CONTRAST_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        pcsg_pkg::REG_TINT: begin
          cfg.tint_rgb <= pwdata[23:0];
        end
        pcsg_pkg::REG_BRIGHTNESS: begin
          cfg.brightness <= pwdata[15:0];
        end
        pcsg_pkg::REG_CONTRAST: begin
          cfg.contrast <= pwdata[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pcsg_pkg::REG_TINT:       prdata = {8'b0, cfg.tint_rgb};
      pcsg_pkg::REG_BRIGHTNESS: prdata = {16'b0, cfg.brightness};
      pcsg_pkg::REG_CONTRAST:   prdata = {16'b0, cfg.contrast};
      default:                  prdata = 32'b0;
    endcase
  end

endmodule

@@ rtl/pcsg_ctrl.sv @@
// Pipeline flow control: one valid bit per stage and the per-stage load enables.
// Depends on pcsg_pkg and the assertion macros header.
`include "palette_color_shade_generator_defines.svh"

module pcsg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output pcsg_pkg::stage_vec_t load
);

  localparam int LAST = pcsg_pkg::NUM_STAGES - 1;

  pcsg_pkg::stage_vec_t v;
  logic in_acc;
  logic out_acc;

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    load[LAST] = !v[LAST] || m_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      load[k] = !v[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (load[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_tready = load[0];
  assign m_tvalid = v[LAST];
  assign in_acc = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  `PCSG_ASSERT_NOW(a_empty_after_reset, $past(rst), v == '0, "Pipeline not empty after reset")
  `PCSG_ASSERT_NOW(a_no_stall_when_drained, !v[LAST], s_tready, "Input stalled with empty output stage")
  `PCSG_ASSERT_NOW(a_item_count, !$past(rst), $countones(v) == $past($countones(v)) + $past(in_acc) - $past(out_acc), "Transaction lost or duplicated in pipeline")

endmodule

@@ rtl/pcsg_channel.sv @@
// Eight-stage datapath for one color channel: tint, contrast, brightness,
// shade and clamp. Depends on pcsg_pkg and the assertion macros header.
`include "palette_color_shade_generator_defines.svh"

module pcsg_channel (
  input  logic                 clk,
  input  logic                 rst,
  input  pcsg_pkg::stage_vec_t load,
  input  pcsg_pkg::cfg_t       cfg,
  input  logic [7:0]           tint,
  input  logic [7:0]           base,
  input  logic [5:0]           level,
  output logic [7:0]           result
);

  logic [15:0] p1;
  logic [8:0]  b1;
  logic [5:0]  f0, f1, f2, f3, f4, f5;
  logic [24:0] p2;
  logic [16:0] ym2;
  logic        neg2, neg3, neg4, neg5;
  logic [32:0] p3;
  logic [11:0] zs4;
  logic [17:0] p4;

  logic [25:0] t_div;
  logic [8:0]  biased;
  logic [24:0] p2_next;
  logic [25:0] y_div;
  logic [16:0] y;
  logic [32:0] p3_next;
  logic [25:0] z_div;
  logic [11:0] zs_next;
  logic [17:0] p4_next;
  logic [7:0]  result_next;

  assign t_div = pcsg_pkg::div255({18'b0, p1});
  assign biased = {1'b0, t_div[7:0]} + pcsg_pkg::CONTRAST_BIAS;
  assign p2_next = {16'b0, b1} * {9'b0, cfg.contrast};

  assign y_div = pcsg_pkg::div255({9'b0, p2});
  assign y = y_div[16:0];

  assign p3_next = {16'b0, ym2} * {17'b0, cfg.brightness};

  assign z_div = pcsg_pkg::div255({1'b0, p3});
  assign zs_next = (z_div >= {14'b0, pcsg_pkg::SHADE_SAT}) ? pcsg_pkg::SHADE_SAT : z_div[11:0];

  assign p4_next = {6'b0, zs4} * {12'b0, f5};

  // A negative value after contrast stays non-positive and clamps to zero.
  always_comb begin
    if (neg5) begin
      result_next = 8'd0;
    end else if (p4 >= {6'b0, pcsg_pkg::SHADE_SAT}) begin
      result_next = pcsg_pkg::CHAN_MAX;
    end else begin
      result_next = pcsg_pkg::div15(p4[11:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      p1 <= {8'b0, base} * {8'b0, tint};
      f0 <= pcsg_pkg::shade_factor(level);
    end
    if (load[1]) begin
      b1 <= biased;
      f1 <= f0;
    end
    if (load[2]) begin
      p2 <= p2_next;
      f2 <= f1;
    end
    if (load[3]) begin
      ym2 <= y - {8'b0, pcsg_pkg::CONTRAST_BIAS};
      neg2 <= y < {8'b0, pcsg_pkg::CONTRAST_BIAS};
      f3 <= f2;
    end
    if (load[4]) begin
      p3 <= p3_next;
      neg3 <= neg2;
      f4 <= f3;
    end
    if (load[5]) begin
      zs4 <= zs_next;
      neg4 <= neg3;
      f5 <= f4;
    end
    if (load[6]) begin
      p4 <= p4_next;
      neg5 <= neg4;
    end
    if (load[7]) begin
      result <= result_next;
    end
  end

  `PCSG_ASSERT_NEXT(a_negative_clamps_low, load[7] && neg5, result == 8'd0, "Negative channel not clamped to zero")
  `PCSG_ASSERT_NEXT(a_overflow_clamps_high, load[7] && !neg5 && (p4 >= {6'b0, pcsg_pkg::SHADE_SAT}), result == pcsg_pkg::CHAN_MAX, "Large channel not clamped to full scale")
  `PCSG_ASSERT_NEXT(a_shade_input_bounded, load[5], zs4 <= pcsg_pkg::SHADE_SAT, "Shade input above saturation bound")

endmodule

@@ rtl/palette_color_shade_generator.sv @@
// A result is valid once its accepted input has passed the eight register stages
// of the channel datapath (each holding at most one multiply or one constant
// division), which set the throughput: one color per cycle while m_tready does
// not stall the pipeline. Reset: synchronous; empties the pipeline and loads tint
// 0xFFFFFF, brightness 255 and contrast 255. Depends on pcsg_pkg and the pcsg modules.
module palette_color_shade_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,  // in_red, in_green, in_blue, shade_level
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,  // out_red, out_green, out_blue
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcsg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  pcsg_pkg::cfg_t       cfg;
  pcsg_pkg::stage_vec_t load;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;

  pcsg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .load     (load)
  );

  pcsg_channel u_red (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .cfg    (cfg),
    .tint   (cfg.tint_rgb[23:16]),
    .base   (s_tdata[7:0]),
    .level  (s_tdata[29:24]),
    .result (out_red)
  );

  pcsg_channel u_green (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .cfg    (cfg),
    .tint   (cfg.tint_rgb[15:8]),
    .base   (s_tdata[15:8]),
    .level  (s_tdata[29:24]),
    .result (out_green)
  );

  pcsg_channel u_blue (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .cfg    (cfg),
    .tint   (cfg.tint_rgb[7:0]),
    .base   (s_tdata[23:16]),
    .level  (s_tdata[29:24]),
    .result (out_blue)
  );

  assign m_tdata = {out_blue, out_green, out_red};

endmodule
